[rtl/core/alternating_bit_sender_assert.svh]
// assertion helpers shared by the sender modules
// each expects clk_i and rst_ni in the enclosing scope
`ifndef ALTERNATING_BIT_SENDER_ASSERT_SVH
`define ALTERNATING_BIT_SENDER_ASSERT_SVH

// condition holds at every clock edge
`define ABS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define ABS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/abs_pkg.sv]
`default_nettype none

package abs_pkg;

  localparam int PAYLOAD_BYTES_DEF = 20;

  // input item kinds
  localparam logic [1:0] ACT_MSG   = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_TIMER = 2'd2;

  // result item kinds
  localparam logic KIND_PKT  = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  localparam int TDATA_IN_W  = 104;
  localparam int TDATA_OUT_W = 48;

  typedef struct packed {
    logic run_start;    // first byte of a new run
    logic clear_store;  // forget stored message bytes
    logic acc_en;       // message or ack byte accepted
    logic store_en;     // write byte into the message store
    logic ack_capture;  // last ack byte: latch header words
    logic save_chk;     // compute packet checksum from byte sum
    logic emit_start;   // rewind the packet read pointer
    logic emit_run;     // stream stored packet out
    logic load_stop;    // load a stop timer item
    logic seq_bit;      // current sequence bit
  } abs_cmd_t;

  typedef struct packed {
    logic emit_done;    // last packet byte handed to output register
    logic ack_ok;       // latched ack is valid and matches
    logic slot_free;    // output register can take an item
  } abs_sts_t;

endpackage

`default_nettype wire

[rtl/core/alternating_bit_sender.sv]
// alternating bit sender
// input stream s_axis: one item per message byte, ack byte or timer expiry.
//   tuser carries the kind, tlast flags the final byte of a run; the ack header
//   words in tdata are only looked at with the final ack byte.
// output stream m_axis: packet bytes toward the network (tuser 0) or a stop
//   timer command (tuser 1); tlast and start_timer mark the last packet byte.
// a message byte or ack byte that does not close a run leaves the input
//   ready; the next item can follow directly.
// closing a message run: a checksum step, then PAYLOAD_BYTES bytes read
//   from the message store one per cycle while the output register is free;
//   each byte passes the read register and then the output register, and the
//   input is held off until the last byte is in the output register. a timer
//   expiry while a message is in transit resends without the checksum step;
//   otherwise it is dropped.
// closing an ack run: the check uses the registered header words; if it
//   passes, a stop command is loaded into m_axis once the output is free.
// a stalled receiver holds off the packet reads and keeps the output item;
//   s_axis_tready stays low until the last packet byte is loaded to m_axis.
// reset clears the sequence bit, the in-transit mark, the open run and the
//   stored message (it reads as zeros); no sweep is needed.
`default_nettype none

module alternating_bit_sender #(
  parameter int PAYLOAD_BYTES = abs_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // data_byte[7:0], pkt_seq[39:8], pkt_ack[71:40], pkt_check[103:72]
  input  wire logic [abs_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  // action[1:0]
  input  wire logic [1:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // seq_num[0], checksum_word[32:1], payload_byte[40:33], start_timer[41], zeros
  output logic [abs_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
  // end_of_packet
  output logic                                  m_axis_tlast,
  // out_kind[0]
  output logic                                  m_axis_tuser
);
  import abs_pkg::*;

  abs_cmd_t cmd;
  abs_sts_t sts;

  logic        seq_num;
  logic [31:0] checksum_word;
  logic [7:0]  payload_byte;
  logic        start_timer;

  abs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abs_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_byte_i     (s_axis_tdata[7:0]),
    .pkt_seq_i       (s_axis_tdata[39:8]),
    .pkt_ack_i       (s_axis_tdata[71:40]),
    .pkt_check_i     (s_axis_tdata[103:72]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_kind_o      (m_axis_tuser),
    .seq_num_o       (seq_num),
    .checksum_word_o (checksum_word),
    .payload_byte_o  (payload_byte),
    .end_of_packet_o (m_axis_tlast),
    .start_timer_o   (start_timer)
  );

  assign m_axis_tdata = {6'd0, start_timer, payload_byte, checksum_word, seq_num};

endmodule

`default_nettype wire

[rtl/core/abs_ctrl.sv]
`default_nettype none
`include "alternating_bit_sender_assert.svh"

module abs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       action_i,
  input  wire logic             last_i,
  input  wire abs_pkg::abs_sts_t sts_i,
  output abs_pkg::abs_cmd_t     cmd_o
);
  import abs_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_FIN_MSG = 2'd1;
  localparam logic [1:0] S_FIN_ACK = 2'd2;
  localparam logic [1:0] S_EMIT    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_transit_q, in_transit_d;
  logic       seq_bit_q, seq_bit_d;
  logic       run_open_q, run_open_d;
  logic       run_is_ack_q, run_is_ack_d;
  logic       dropping_q, dropping_d;

  logic accept;
  logic is_byte;
  logic is_ack;
  logic new_run;
  logic drop_eff;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_ack     = (action_i == ACT_ACK);
  assign is_byte    = (action_i == ACT_MSG) || is_ack;
  assign new_run    = !run_open_q || (run_is_ack_q != is_ack);
  assign drop_eff   = new_run ? (!is_ack && in_transit_q) : dropping_q;

  always_comb begin
    state_d      = state_q;
    in_transit_d = in_transit_q;
    seq_bit_d    = seq_bit_q;
    run_open_d   = run_open_q;
    run_is_ack_d = run_is_ack_q;
    dropping_d   = dropping_q;
    cmd_o        = '0;
    cmd_o.seq_bit = seq_bit_q;

    case (state_q)
      S_IDLE: begin
        if (accept && is_byte) begin
          cmd_o.acc_en      = 1'b1;
          cmd_o.run_start   = new_run;
          cmd_o.clear_store = new_run && !is_ack && !drop_eff;
          cmd_o.store_en    = !is_ack && !drop_eff;
          if (last_i) begin
            run_open_d = 1'b0;
            dropping_d = 1'b0;
            if (is_ack) begin
              cmd_o.ack_capture = 1'b1;
              state_d = S_FIN_ACK;
            end else if (!drop_eff) begin
              state_d = S_FIN_MSG;
            end
          end else begin
            run_open_d   = 1'b1;
            run_is_ack_d = is_ack;
            dropping_d   = drop_eff;
          end
        end else if (accept && (action_i == ACT_TIMER) && in_transit_q) begin
          cmd_o.emit_start = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_FIN_MSG: begin
        cmd_o.save_chk   = 1'b1;
        cmd_o.emit_start = 1'b1;
        in_transit_d     = 1'b1;
        state_d          = S_EMIT;
      end
      S_FIN_ACK: begin
        if (!sts_i.ack_ok) begin
          state_d = S_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.load_stop = 1'b1;
          in_transit_d    = 1'b0;
          seq_bit_d       = !seq_bit_q;
          state_d         = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.emit_run = 1'b1;
        if (sts_i.emit_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_transit_q <= 1'b0;
      seq_bit_q    <= 1'b0;
      run_open_q   <= 1'b0;
      run_is_ack_q <= 1'b0;
      dropping_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_transit_q <= in_transit_d;
      seq_bit_q    <= seq_bit_d;
      run_open_q   <= run_open_d;
      run_is_ack_q <= run_is_ack_d;
      dropping_q   <= dropping_d;
    end
  end

  `ABS_ASSERT_IMP(a_emit_in_transit, state_q == S_EMIT, in_transit_q, "resend without message in transit")
  `ABS_ASSERT_IMP(a_fin_msg_to_emit, state_q == S_FIN_MSG, state_d == S_EMIT, "checksum step did not start packet")
  `ABS_ASSERT_NEXT(a_seq_flip, cmd_o.load_stop, seq_bit_q != $past(seq_bit_q), "sequence bit did not flip on stop")
  `ABS_ASSERT_IMP(a_drop_in_run, dropping_q, run_open_q && !run_is_ack_q, "drop mark outside an open message run")

endmodule

`default_nettype wire

[rtl/core/abs_dpath.sv]
`default_nettype none
`include "alternating_bit_sender_assert.svh"

module abs_dpath #(
  parameter int PAYLOAD_BYTES = abs_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire abs_pkg::abs_cmd_t cmd_i,
  output abs_pkg::abs_sts_t      sts_o,
  input  wire logic signed [7:0]  data_byte_i,
  input  wire logic signed [31:0] pkt_seq_i,
  input  wire logic signed [31:0] pkt_ack_i,
  input  wire logic signed [31:0] pkt_check_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   out_kind_o,
  output logic                   seq_num_o,
  output logic signed [31:0]     checksum_word_o,
  output logic signed [7:0]      payload_byte_o,
  output logic                   end_of_packet_o,
  output logic                   start_timer_o
);
  import abs_pkg::*;

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CW = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [CW-1:0] NBytes  = CW'(PAYLOAD_BYTES);
  localparam logic [CW-1:0] LastIdx = CW'(PAYLOAD_BYTES - 1);

  // message store
  logic [7:0]               mem [PAYLOAD_BYTES];
  logic [PAYLOAD_BYTES-1:0] valid_q, valid_d;

  logic [CW-1:0] byte_idx_q;
  logic [CW-1:0] idx_eff;
  logic          in_range;
  logic [31:0]   sum_q;
  logic [31:0]   sum_base;
  logic [31:0]   byte_ext;
  logic [31:0]   saved_chk_q;
  logic [31:0]   ack_a_q;
  logic [31:0]   pchk_q;
  logic          pseq_match_q;

  // packet read pipe
  logic [CW-1:0] rd_cnt_q;
  logic          rd_pend_q;
  logic [7:0]    rdata_q;
  logic          rvld_q;
  logic          rd_last_q;
  logic          issue;
  logic          load_pkt;
  logic          slot_free;

  logic          out_valid_q;
  logic          out_kind_q;
  logic          seq_q;
  logic [31:0]   chk_q;
  logic [7:0]    pbyte_q;
  logic          eop_q;

  assign idx_eff  = cmd_i.run_start ? '0 : byte_idx_q;
  assign in_range = (idx_eff < NBytes);
  assign sum_base = cmd_i.run_start ? 32'd0 : sum_q;
  assign byte_ext = in_range ? {{24{data_byte_i[7]}}, data_byte_i} : 32'd0;

  always_comb begin
    valid_d = cmd_i.clear_store ? '0 : valid_q;
    if (cmd_i.store_en && in_range) begin
      valid_d[idx_eff[AW-1:0]] = 1'b1;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign load_pkt  = rd_pend_q && slot_free;
  assign issue     = cmd_i.emit_run && (rd_cnt_q < NBytes) && (!rd_pend_q || load_pkt);

  assign sts_o.slot_free = slot_free;
  assign sts_o.emit_done = load_pkt && rd_last_q;
  // total == all ones is the same as a + sum == ~check
  assign sts_o.ack_ok    = pseq_match_q && ((ack_a_q + sum_q) == ~pchk_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en && in_range) begin
      mem[idx_eff[AW-1:0]] <= data_byte_i;
    end
    if (issue) begin
      rdata_q   <= mem[rd_cnt_q[AW-1:0]];
      rvld_q    <= valid_q[rd_cnt_q[AW-1:0]];
      rd_last_q <= (rd_cnt_q == LastIdx);
    end
    if (cmd_i.ack_capture) begin
      ack_a_q      <= pkt_seq_i + pkt_ack_i;
      pchk_q       <= pkt_check_i;
      pseq_match_q <= (pkt_seq_i == {31'd0, cmd_i.seq_bit});
    end
    if (cmd_i.save_chk) begin
      saved_chk_q <= ~(sum_q + {30'd0, cmd_i.seq_bit, 1'b0});
    end
    if (load_pkt) begin
      out_kind_q <= KIND_PKT;
      seq_q      <= cmd_i.seq_bit;
      chk_q      <= saved_chk_q;
      pbyte_q    <= rvld_q ? rdata_q : 8'd0;
      eop_q      <= rd_last_q;
    end else if (cmd_i.load_stop) begin
      out_kind_q <= KIND_STOP;
      seq_q      <= cmd_i.seq_bit;
      chk_q      <= 32'd0;
      pbyte_q    <= 8'd0;
      eop_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      byte_idx_q  <= '0;
      sum_q       <= 32'd0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.acc_en) begin
        byte_idx_q <= in_range ? idx_eff + CW'(1) : idx_eff;
        sum_q      <= sum_base + byte_ext;
      end
      if (cmd_i.emit_start) begin
        rd_cnt_q  <= '0;
        rd_pend_q <= 1'b0;
      end else begin
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        rd_pend_q <= issue ? 1'b1 : (load_pkt ? 1'b0 : rd_pend_q);
      end
      if (load_pkt || cmd_i.load_stop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign seq_num_o       = seq_q;
  assign checksum_word_o = chk_q;
  assign payload_byte_o  = pbyte_q;
  assign end_of_packet_o = eop_q;
  assign start_timer_o   = eop_q;

  `ABS_ASSERT_ALWAYS(a_one_load, !(load_pkt && cmd_i.load_stop), "packet byte and stop loaded together")
  `ABS_ASSERT_IMP(a_pend_in_emit, !cmd_i.emit_run, !rd_pend_q, "packet byte pending outside a resend")
  `ABS_ASSERT_ALWAYS(a_rd_cnt_range, rd_cnt_q <= NBytes, "packet read pointer past the store")

endmodule

`default_nettype wire
